// File: src/gpb_pkg.sv
// Shared types, address map and constants for the GPIO port bank.
package gpb_pkg;

    localparam int NUM_PORTS = 16;
    localparam int ADDR_W    = 10;
    localparam int PORT_W    = 4;
    localparam int BYTE_W    = 8;

    localparam logic [PORT_W-1:0] PROT_PORT = 4'd9;
    localparam logic [ADDR_W-1:0] ADDR_SEL_CTL = 10'h3af;
    localparam logic [ADDR_W-1:0] DIR_OFFSET   = 10'h002;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Data register of each port; the direction register sits two above it
    localparam logic [ADDR_W-1:0] DATA_ADDR [16] = '{
        10'h3e0, 10'h3e1, 10'h3e4, 10'h3e5, 10'h3e8, 10'h3e9, 10'h3c0, 10'h3c1,
        10'h3c4, 10'h3c5, 10'h3c8, 10'h3c9, 10'h3cc, 10'h3cd, 10'h3d0, 10'h3d1
    };

    // Function-select registers; the first six ports have none
    localparam logic [15:0] FSEL_PRESENT = 16'hffc0;
    localparam logic [ADDR_W-1:0] FSEL_ADDR [16] = '{
        10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h3b0, 10'h3b1,
        10'h3b4, 10'h3b5, 10'h3b8, 10'h3b9, 10'h3bc, 10'h3bd, 10'h3a0, 10'h3a1
    };

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_DATA,
        KIND_DIR,
        KIND_FSEL,
        KIND_SELCTL
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [PORT_W-1:0] port;
    } decode_t;

    typedef struct packed {
        logic              cmd;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] wdata;
        logic [BYTE_W-1:0] pin_levels;
        logic [BYTE_W-1:0] pull_select;
        logic              protect_open;
    } req_t;

    typedef struct packed {
        logic [BYTE_W-1:0] rdata;
        logic              write_blocked;
        logic [PORT_W-1:0] port_index;
        logic [BYTE_W-1:0] drive_enable;
        logic [BYTE_W-1:0] drive_level;
        logic [BYTE_W-1:0] pullup_on;
    } rsp_t;

    typedef struct packed {
        logic              latch_we;
        logic              dir_we;
        logic              sel_we;
        logic [PORT_W-1:0] port;
        logic [BYTE_W-1:0] wdata;
    } regwr_t;

    typedef struct packed {
        logic [BYTE_W-1:0] dir;
        logic [BYTE_W-1:0] latch;
        logic [BYTE_W-1:0] sel;
    } regrd_t;

endpackage

// File: src/gpb_decode.sv
// Address decoder: maps a byte address to a register kind and port number.
module gpb_decode
(
    input  logic [gpb_pkg::ADDR_W-1:0] addr,
    output gpb_pkg::decode_t           dec
);

    always_comb
    begin
        logic found;
        found    = 1'b0;
        dec.kind = gpb_pkg::KIND_NONE;
        dec.port = '0;
        for (int i = 0; i < gpb_pkg::NUM_PORTS; i++)
        begin
            if (!found)
            begin
                if (addr == gpb_pkg::DATA_ADDR[i])
                begin
                    found    = 1'b1;
                    dec.kind = gpb_pkg::KIND_DATA;
                    dec.port = gpb_pkg::PORT_W'(i);
                end
                else if (addr == gpb_pkg::DATA_ADDR[i] + gpb_pkg::DIR_OFFSET)
                begin
                    found    = 1'b1;
                    dec.kind = gpb_pkg::KIND_DIR;
                    dec.port = gpb_pkg::PORT_W'(i);
                end
                else if (gpb_pkg::FSEL_PRESENT[i] && addr == gpb_pkg::FSEL_ADDR[i])
                begin
                    found    = 1'b1;
                    dec.kind = gpb_pkg::KIND_FSEL;
                    dec.port = gpb_pkg::PORT_W'(i);
                end
            end
        end
        if (!found && addr == gpb_pkg::ADDR_SEL_CTL)
        begin
            dec.kind = gpb_pkg::KIND_SELCTL;
        end
    end

endmodule

// File: src/gpb_regfile.sv
// Port register file: data latches, direction registers and the select-control byte.
module gpb_regfile
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  gpb_pkg::regwr_t            wr,
    input  logic [gpb_pkg::PORT_W-1:0] rd_port,
    output gpb_pkg::regrd_t            rd
);

    logic [gpb_pkg::BYTE_W-1:0] latch_reg [gpb_pkg::NUM_PORTS];
    logic [gpb_pkg::BYTE_W-1:0] dir_reg   [gpb_pkg::NUM_PORTS];
    logic [gpb_pkg::BYTE_W-1:0] sel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < gpb_pkg::NUM_PORTS; i++)
            begin
                latch_reg[i] <= '0;
                dir_reg[i]   <= '0;
            end
            sel_reg <= '0;
        end
        else
        begin
            if (wr.latch_we)
            begin
                latch_reg[wr.port] <= wr.wdata;
            end
            if (wr.dir_we)
            begin
                dir_reg[wr.port] <= wr.wdata;
            end
            if (wr.sel_we)
            begin
                sel_reg <= wr.wdata;
            end
        end
    end

    assign rd.dir   = dir_reg[rd_port];
    assign rd.latch = latch_reg[rd_port];
    assign rd.sel   = sel_reg;

endmodule

// File: src/gpio_port_bank_unit.sv
// GPIO port bank top level: input register, access logic and result register.
// An accepted item waits in the input register and moves into the result register, which
// drives rsp_valid, once that register is empty or rsp_ready is high. Throughput: one
// item per cycle while rsp_ready does not stall a full result register; the register
// file is updated as an item leaves the input register, so the next item sees its effect.
// Reset: data latches, direction registers (all inputs), select byte and both stages clear.
module gpio_port_bank_unit
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  gpb_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output gpb_pkg::rsp_t rsp
);

    logic            s1_valid_reg, s1_valid_next;
    gpb_pkg::req_t   s1_reg, s1_next;
    logic            out_valid_reg, out_valid_next;
    gpb_pkg::rsp_t   out_reg, out_next;

    logic              advance;
    logic              fire;
    gpb_pkg::decode_t  dec;
    gpb_pkg::regwr_t   wr;
    gpb_pkg::regrd_t   rd;
    gpb_pkg::rsp_t     res;
    logic              is_wr;
    logic              hit;
    logic              blocked;
    logic [gpb_pkg::BYTE_W-1:0] dir_after;
    logic [gpb_pkg::BYTE_W-1:0] latch_after;

    assign advance   = !out_valid_reg || rsp_ready;
    assign req_ready = !s1_valid_reg || advance;
    assign fire      = s1_valid_reg && advance;

    gpb_decode u_decode
    (
        .addr (s1_reg.addr),
        .dec  (dec)
    );

    gpb_regfile u_regfile
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd_port (dec.port),
        .rd      (rd)
    );

    assign is_wr   = (s1_reg.cmd == gpb_pkg::CMD_WRITE);
    assign blocked = is_wr && dec.kind == gpb_pkg::KIND_DIR
                     && dec.port == gpb_pkg::PROT_PORT && !s1_reg.protect_open;

    always_comb
    begin
        wr.latch_we = fire && is_wr && dec.kind == gpb_pkg::KIND_DATA;
        wr.dir_we   = fire && is_wr && dec.kind == gpb_pkg::KIND_DIR && !blocked;
        wr.sel_we   = fire && is_wr && dec.kind == gpb_pkg::KIND_SELCTL;
        wr.port     = dec.port;
        wr.wdata    = s1_reg.wdata;
    end

    // Per-port outputs report the state as it stands after this access
    assign dir_after   = (is_wr && dec.kind == gpb_pkg::KIND_DIR && !blocked)
                         ? s1_reg.wdata : rd.dir;
    assign latch_after = (is_wr && dec.kind == gpb_pkg::KIND_DATA)
                         ? s1_reg.wdata : rd.latch;

    always_comb
    begin
        hit       = 1'b0;
        res.rdata = '0;
        case (dec.kind)
            gpb_pkg::KIND_DATA:
            begin
                hit       = 1'b1;
                res.rdata = (rd.dir & rd.latch) | (~rd.dir & s1_reg.pin_levels);
            end
            gpb_pkg::KIND_DIR:
            begin
                hit       = 1'b1;
                res.rdata = rd.dir;
            end
            gpb_pkg::KIND_FSEL:
            begin
                hit = 1'b1;
            end
            gpb_pkg::KIND_SELCTL:
            begin
                res.rdata = rd.sel;
            end
            default:
            begin
                hit = 1'b0;
            end
        endcase
        if (is_wr)
        begin
            res.rdata = '0;
        end
        res.write_blocked = blocked;
        res.port_index    = hit ? dec.port : '0;
        res.drive_enable  = hit ? dir_after : '0;
        res.drive_level   = hit ? latch_after : '0;
        res.pullup_on     = hit ? (~dir_after & ~s1_reg.pull_select) : '0;
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_next       = s1_reg;
        if (req_ready)
        begin
            s1_valid_next = req_valid;
            if (req_valid)
            begin
                s1_next = req;
            end
        end
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (advance)
        begin
            out_valid_next = s1_valid_reg;
            if (s1_valid_reg)
            begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg  <= s1_next;
        out_reg <= out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

`ifndef SYNTHESIS
    a_blocked_no_rdata: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.write_blocked |-> rsp.rdata == '0)
        else $error("blocked write returned read data");

    a_blocked_port: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.write_blocked |-> rsp.port_index == gpb_pkg::PROT_PORT)
        else $error("write blocked on an unprotected port");

    a_pullup_inputs_only: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.pullup_on & rsp.drive_enable) == '0)
        else $error("pull-up reported on a driven pin");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("input stalled with empty result register");
`endif

endmodule
